@@ src/lsfg_pkg.sv @@
package lsfg_pkg;

    localparam int FREQ_BITS_DEF = 24;
    localparam int PCT_W = 7;
    localparam int CNT_W = 8;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int QUEUE_DEPTH = 8;

    // Exact floor(x / 100) for any 32-bit x: (x * DIV100_MUL) >> DIV100_SHIFT.
    localparam logic [63:0] DIV100_MUL = 64'd1374389535;
    localparam int DIV100_SHIFT = 37;
    localparam int PCT_DIV = 100;

    // Exact floor(c / 100) for c below 2^14: (c * FRAC_MUL) >> FRAC_SHIFT.
    localparam int FRAC_W = 14;
    localparam int FRAC_PROD_W = 27;
    localparam logic [FRAC_PROD_W-1:0] FRAC_MUL = 27'd5243;
    localparam int FRAC_SHIFT = 19;

    localparam int FALLBACK_STEP = 5;
    localparam logic [CNT_W-1:0] COUNTER_MAX = 8'hFF;

    localparam logic REQ_NOTICE = 1'b1;
    localparam logic REL_DOWN = 1'b0;
    localparam logic REL_UP = 1'b1;

    typedef enum logic [2:0] {
        REG_UP_THR       = 3'd0,
        REG_DOWN_THR     = 3'd1,
        REG_DOWN_THR_OFF = 3'd2,
        REG_STEP_PCT     = 3'd3,
        REG_BOOST_EN     = 3'd4,
        REG_BOOST_TRIG   = 3'd5,
        REG_BOOST_TOP    = 3'd6
    } reg_idx_t;

    localparam logic [PCT_W-1:0] UP_THR_RST = 7'd85;
    localparam logic [PCT_W-1:0] DOWN_THR_RST = 7'd35;
    localparam logic [PCT_W-1:0] DOWN_THR_OFF_RST = 7'd45;
    localparam logic [PCT_W-1:0] STEP_PCT_RST = 7'd5;
    localparam logic BOOST_EN_RST = 1'b1;
    localparam logic [CNT_W-1:0] BOOST_TRIG_RST = 8'd8;
    localparam logic [CNT_W-1:0] BOOST_TOP_RST = 8'd12;

    typedef struct packed {
        logic [PCT_W-1:0] up_thr;
        logic [PCT_W-1:0] down_thr;
        logic [PCT_W-1:0] down_thr_off;
        logic [PCT_W-1:0] step_pct;
        logic             boost_en;
        logic [CNT_W-1:0] boost_trig;
        logic [CNT_W-1:0] boost_top;
    } cfg_t;

    typedef enum logic [2:0] {
        CLS_NONE     = 3'd0,
        CLS_NOTICE   = 3'd1,
        CLS_DOWN_ON  = 3'd2,
        CLS_DOWN_OFF = 3'd3,
        CLS_UP       = 3'd4
    } cls_t;

endpackage

@@ src/lsfg_if.sv @@
interface lsfg_req_if
    import lsfg_pkg::*;
#(
    parameter int FREQ_BITS = FREQ_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [PCT_W-1:0]     load;
    logic                 screen_on;
    logic [FREQ_BITS-1:0] current_freq;
    logic [FREQ_BITS-1:0] policy_min;
    logic [FREQ_BITS-1:0] policy_max;
    logic [FREQ_BITS-1:0] new_freq;

    modport source (
        output valid, req_type, load, screen_on, current_freq, policy_min, policy_max,
               new_freq,
        input  ready
    );

    modport sink (
        input  valid, req_type, load, screen_on, current_freq, policy_min, policy_max,
               new_freq,
        output ready
    );
endinterface

interface lsfg_res_if
    import lsfg_pkg::*;
#(
    parameter int FREQ_BITS = FREQ_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [FREQ_BITS-1:0] target_freq;
    logic                 relation;

    modport source (
        output valid, target_freq, relation,
        input  ready
    );

    modport sink (
        input  valid, target_freq, relation,
        output ready
    );
endinterface

@@ src/lsfg_regs.sv @@
module lsfg_regs
    import lsfg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);
    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_UP_THR:       cfg_next.up_thr = pwdata[PCT_W-1:0];
                REG_DOWN_THR:     cfg_next.down_thr = pwdata[PCT_W-1:0];
                REG_DOWN_THR_OFF: cfg_next.down_thr_off = pwdata[PCT_W-1:0];
                REG_STEP_PCT:     cfg_next.step_pct = pwdata[PCT_W-1:0];
                REG_BOOST_EN:     cfg_next.boost_en = pwdata[0];
                REG_BOOST_TRIG:   cfg_next.boost_trig = pwdata[CNT_W-1:0];
                REG_BOOST_TOP:    cfg_next.boost_top = pwdata[CNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_UP_THR:       prdata = APB_DATA_W'(cfg_reg.up_thr);
            REG_DOWN_THR:     prdata = APB_DATA_W'(cfg_reg.down_thr);
            REG_DOWN_THR_OFF: prdata = APB_DATA_W'(cfg_reg.down_thr_off);
            REG_STEP_PCT:     prdata = APB_DATA_W'(cfg_reg.step_pct);
            REG_BOOST_EN:     prdata = APB_DATA_W'(cfg_reg.boost_en);
            REG_BOOST_TRIG:   prdata = APB_DATA_W'(cfg_reg.boost_trig);
            REG_BOOST_TOP:    prdata = APB_DATA_W'(cfg_reg.boost_top);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_thr       <= UP_THR_RST;
            cfg_reg.down_thr     <= DOWN_THR_RST;
            cfg_reg.down_thr_off <= DOWN_THR_OFF_RST;
            cfg_reg.step_pct     <= STEP_PCT_RST;
            cfg_reg.boost_en     <= BOOST_EN_RST;
            cfg_reg.boost_trig   <= BOOST_TRIG_RST;
            cfg_reg.boost_top    <= BOOST_TOP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

@@ src/lsfg_front.sv @@
module lsfg_front
    import lsfg_pkg::*;
#(
    parameter int FREQ_BITS = FREQ_BITS_DEF,
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    lsfg_req_if.sink                     req,
    input  logic [$clog2(DEPTH+1)-1:0]   q_count,
    output logic                         push,
    output cls_t                         cls,
    output logic [FREQ_BITS:0]           step,
    output logic [FREQ_BITS-1:0]         pmin,
    output logic [FREQ_BITS-1:0]         pmax,
    output logic [FREQ_BITS-1:0]         nf
);
    localparam int FB = FREQ_BITS;
    localparam int QW = FB - 6;
    localparam int STEP_W = FB + 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SUM_W = CW + 1;

    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    cls_t       cls1_reg, cls2_reg, cls3_reg, cls4_reg;
    logic [FB-1:0] pmin1_reg, pmin2_reg, pmin3_reg, pmin4_reg;
    logic [FB-1:0] pmax1_reg, pmax2_reg, pmax3_reg, pmax4_reg;
    logic [FB-1:0] nf1_reg, nf2_reg, nf3_reg, nf4_reg;
    logic [QW-1:0] q1_reg;
    logic [STEP_W-1:0] m2_reg, m3_reg;
    logic [PCT_W-1:0]  b2_reg;
    logic [FRAC_W-1:0] c3_reg;
    logic [STEP_W-1:0] step4_reg;

    logic              accept;
    cls_t              cls1_next;
    logic [63:0]       div_prod;
    logic [QW-1:0]     q1_next;
    logic [STEP_W-1:0] m2_next;
    logic [FB-1:0]     rem_full;
    logic [FRAC_W-1:0] c3_next;
    logic [FRAC_PROD_W-1:0] frac_prod;
    logic [STEP_W-1:0] step_sum;
    logic [STEP_W-1:0] step4_next;
    logic [2:0]        in_flight;

    assign in_flight = 3'(v1_reg) + 3'(v2_reg) + 3'(v3_reg) + 3'(v4_reg);
    assign req.ready = (SUM_W'(q_count) + SUM_W'(in_flight)) < SUM_W'(DEPTH);
    assign accept = req.valid && req.ready;

    always_comb
    begin
        cls1_next = CLS_NONE;
        if (req.req_type == REQ_NOTICE)
        begin
            cls1_next = CLS_NOTICE;
        end
        else if (!req.screen_on && req.current_freq == req.policy_min)
        begin
            cls1_next = CLS_NONE;
        end
        else if (cfg.step_pct == '0)
        begin
            cls1_next = CLS_NONE;
        end
        else if (req.screen_on && req.load < cfg.down_thr)
        begin
            cls1_next = (req.current_freq == req.policy_min) ? CLS_NONE : CLS_DOWN_ON;
        end
        else if (!req.screen_on && req.load <= cfg.down_thr_off)
        begin
            cls1_next = CLS_DOWN_OFF;
        end
        else if (req.load > cfg.up_thr)
        begin
            cls1_next = req.screen_on ? CLS_UP : CLS_NONE;
        end
    end

    assign div_prod = 64'(req.policy_max) * DIV100_MUL;
    assign q1_next = div_prod[DIV100_SHIFT +: QW];

    assign m2_next = STEP_W'(cfg.step_pct) * STEP_W'(q1_reg);
    assign rem_full = pmax1_reg - (FB'(q1_reg) * FB'(PCT_DIV));

    assign c3_next = FRAC_W'(cfg.step_pct) * FRAC_W'(b2_reg);

    assign frac_prod = FRAC_PROD_W'(c3_reg) * FRAC_MUL;
    assign step_sum = m3_reg + STEP_W'(frac_prod[FRAC_PROD_W-1:FRAC_SHIFT]);
    assign step4_next = (step_sum == '0) ? STEP_W'(FALLBACK_STEP) : step_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cls1_reg  <= cls1_next;
        pmin1_reg <= req.policy_min;
        pmax1_reg <= req.policy_max;
        nf1_reg   <= req.new_freq;
        q1_reg    <= q1_next;

        cls2_reg  <= cls1_reg;
        pmin2_reg <= pmin1_reg;
        pmax2_reg <= pmax1_reg;
        nf2_reg   <= nf1_reg;
        m2_reg    <= m2_next;
        b2_reg    <= rem_full[PCT_W-1:0];

        cls3_reg  <= cls2_reg;
        pmin3_reg <= pmin2_reg;
        pmax3_reg <= pmax2_reg;
        nf3_reg   <= nf2_reg;
        m3_reg    <= m2_reg;
        c3_reg    <= c3_next;

        cls4_reg  <= cls3_reg;
        pmin4_reg <= pmin3_reg;
        pmax4_reg <= pmax3_reg;
        nf4_reg   <= nf3_reg;
        step4_reg <= step4_next;
    end

    assign push = v4_reg;
    assign cls  = cls4_reg;
    assign step = step4_reg;
    assign pmin = pmin4_reg;
    assign pmax = pmax4_reg;
    assign nf   = nf4_reg;
endmodule

@@ src/lsfg_queue.sv @@
module lsfg_queue
    import lsfg_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign rdata = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end
endmodule

@@ src/lsfg_back.sv @@
module lsfg_back
    import lsfg_pkg::*;
#(
    parameter int FREQ_BITS = FREQ_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 pop,
    input  cls_t                 cls,
    input  logic [FREQ_BITS:0]   step,
    input  logic [FREQ_BITS-1:0] pmin,
    input  logic [FREQ_BITS-1:0] pmax,
    input  logic [FREQ_BITS-1:0] nf,
    lsfg_res_if.source           res
);
    localparam int FB = FREQ_BITS;
    localparam int STEP_W = FB + 1;
    localparam int WIDE_W = FB + 2;

    logic [FB-1:0]    req_freq_reg, req_freq_next;
    logic [CNT_W-1:0] boost_cnt_reg, boost_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [FB-1:0]    out_freq_reg;
    logic             out_rel_reg;

    logic             take;
    logic             emit;
    logic             rel;
    logic [CNT_W-1:0] cnt_dec;
    logic [FB-1:0]    down_freq;
    logic             down_floor;
    logic signed [CNT_W:0]    level;
    logic signed [WIDE_W-1:0] boost_raw;
    logic [FB-1:0]    boost_freq;
    logic [WIDE_W-1:0] up_sum;
    logic [FB-1:0]    up_freq;

    assign take = in_valid && (!out_valid_reg || res.ready);
    assign pop = take;

    assign cnt_dec = (boost_cnt_reg != '0) ? boost_cnt_reg - 1'b1 : boost_cnt_reg;
    assign down_floor = !(STEP_W'(req_freq_reg) > step);
    assign down_freq = down_floor ? pmin : FB'(STEP_W'(req_freq_reg) - step);

    assign level = $signed({1'b0, cfg.boost_top}) - $signed({1'b0, boost_cnt_reg});
    assign boost_raw = $signed({2'b00, pmax}) - $signed({{(WIDE_W-CNT_W-1){level[CNT_W]}}, level});

    always_comb
    begin
        if (boost_raw[WIDE_W-1])
        begin
            boost_freq = '0;
        end
        else if (boost_raw[FB])
        begin
            boost_freq = '1;
        end
        else
        begin
            boost_freq = boost_raw[FB-1:0];
        end
    end

    assign up_sum = WIDE_W'(req_freq_reg) + WIDE_W'(step);
    assign up_freq = (up_sum[WIDE_W-1:FB] != '0) ? '1 : up_sum[FB-1:0];

    always_comb
    begin
        req_freq_next = req_freq_reg;
        boost_cnt_next = boost_cnt_reg;
        emit = 1'b0;
        rel = REL_DOWN;
        unique case (cls)
            CLS_NOTICE:
            begin
                if (req_freq_reg > pmax || req_freq_reg < pmin)
                begin
                    req_freq_next = nf;
                end
            end
            CLS_DOWN_ON:
            begin
                emit = 1'b1;
                req_freq_next = down_freq;
                boost_cnt_next = down_floor ? '0 : cnt_dec;
            end
            CLS_DOWN_OFF:
            begin
                emit = 1'b1;
                req_freq_next = down_freq;
                boost_cnt_next = down_floor ? '0 : boost_cnt_reg;
            end
            CLS_UP:
            begin
                if (req_freq_reg != pmax)
                begin
                    emit = 1'b1;
                    rel = REL_UP;
                    if (cfg.boost_en && boost_cnt_reg >= cfg.boost_trig)
                    begin
                        req_freq_next = boost_freq;
                        if (level == '0)
                        begin
                            boost_cnt_next = '0;
                        end
                    end
                    else
                    begin
                        req_freq_next = up_freq;
                        if (boost_cnt_reg != COUNTER_MAX)
                        begin
                            boost_cnt_next = boost_cnt_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = emit;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_freq_reg  <= '0;
            boost_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                req_freq_reg  <= req_freq_next;
                boost_cnt_reg <= boost_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_freq_reg <= req_freq_next;
            out_rel_reg  <= rel;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.target_freq = out_freq_reg;
    assign res.relation = out_rel_reg;
endmodule

@@ src/load_step_frequency_governor.sv @@
// Load-step frequency governor with boost.
// Requests arrive on the req channel (valid/ready): a load sample or a
// frequency-change notice, together with the current frequency and policy limits.
// Each load sample that calls for a step down, or a step up while the requested
// frequency is not at the policy maximum, yields one res item: the new target
// frequency in kHz and the rounding relation. Notices and other samples yield none.
// The front section classifies each request and computes the step size in a
// four-stage pipeline with a multiplier in every stage. An eight-entry queue feeds
// the back section, which updates the requested frequency and the boost counter
// as it takes each entry and holds the result in an output register.
// A request passes the four front stages, then the queue and the output register.
// One request is accepted per cycle while res is ready in steady state; the front
// only accepts when the queue can absorb everything in its pipeline.
// When the receiver stalls, the result stays in the output register, the queue
// fills, and req.ready drops once queued and in-flight requests fill its depth.
// Reset clears the requested frequency, the boost counter and all valid state,
// and loads the registers with their defaults. Registers are written over the
// APB port and must only change while no request is in flight.
module load_step_frequency_governor
    import lsfg_pkg::*;
#(
    parameter int FREQ_BITS = FREQ_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    lsfg_req_if.sink              req,
    lsfg_res_if.source            res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    localparam int FB = FREQ_BITS;
    localparam int CLS_W = $bits(cls_t);
    localparam int ENTRY_W = CLS_W + (FB + 1) + 3 * FB;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cfg_t              cfg;
    logic              f_push;
    cls_t              f_cls;
    logic [FB:0]       f_step;
    logic [FB-1:0]     f_pmin, f_pmax, f_nf;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;
    logic              q_pop;
    logic              q_not_empty;
    logic [CW-1:0]     q_count;
    logic [CLS_W-1:0]  q_cls_bits;
    logic [FB:0]       q_step;
    logic [FB-1:0]     q_pmin, q_pmax, q_nf;

    lsfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lsfg_front #(
        .FREQ_BITS (FREQ_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .req     (req),
        .q_count (q_count),
        .push    (f_push),
        .cls     (f_cls),
        .step    (f_step),
        .pmin    (f_pmin),
        .pmax    (f_pmax),
        .nf      (f_nf)
    );

    assign q_wdata = {f_cls, f_step, f_pmin, f_pmax, f_nf};

    lsfg_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    assign {q_cls_bits, q_step, q_pmin, q_pmax, q_nf} = q_rdata;

    lsfg_back #(
        .FREQ_BITS (FREQ_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (q_not_empty),
        .pop      (q_pop),
        .cls      (cls_t'(q_cls_bits)),
        .step     (q_step),
        .pmin     (q_pmin),
        .pmax     (q_pmax),
        .nf       (q_nf),
        .res      (res)
    );
endmodule

@@ bench/tb_load_step_frequency_governor.sv @@
module tb_load_step_frequency_governor;
    import lsfg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FREQ_BITS_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 40;

    typedef logic [FB-1:0] freq_t;
    localparam freq_t FREQ_TOP = '1;

    typedef struct packed {
        logic             req_type;
        logic [PCT_W-1:0] load;
        logic             screen_on;
        freq_t            current_freq;
        freq_t            policy_min;
        freq_t            policy_max;
        freq_t            new_freq;
    } gov_req_t;

    typedef struct packed {
        freq_t target_freq;
        logic  relation;
    } gov_res_t;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lsfg_req_if #(.FREQ_BITS(FB)) req_if ();
    lsfg_res_if #(.FREQ_BITS(FB)) res_if ();

    load_step_frequency_governor #(.FREQ_BITS(FB)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Governor state as the block should hold it.
    freq_t            gov_freq;
    logic [CNT_W-1:0] gov_boost;
    cfg_t             gov_cfg;

    gov_res_t due_targets[$];
    int       mismatches;
    int       hold_cycles;
    int       cycle_cnt;
    int       burst_left;
    bit       steady;
    freq_t    pol_min;
    freq_t    pol_max;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint step_of(longint pmax);
        longint s;
        s = (longint'(gov_cfg.step_pct) * pmax) / 100;
        return (s == 0) ? longint'(FALLBACK_STEP) : s;
    endfunction

    function automatic void lower_freq(longint pmin, longint pmax);
        longint s;
        s = step_of(pmax);
        if (longint'(gov_freq) > s)
            gov_freq = freq_t'(longint'(gov_freq) - s);
        else
        begin
            gov_freq = freq_t'(pmin);
            gov_boost = '0;
        end
    endfunction

    function automatic bit govern(input gov_req_t r, output gov_res_t res);
        longint pmin;
        longint pmax;
        longint lvl;
        longint f;
        pmin = r.policy_min;
        pmax = r.policy_max;
        res = '0;
        if (r.req_type == REQ_NOTICE)
        begin
            if (longint'(gov_freq) > pmax || longint'(gov_freq) < pmin)
                gov_freq = r.new_freq;
            return 1'b0;
        end
        if (!r.screen_on && r.current_freq == r.policy_min)
            return 1'b0;
        if (gov_cfg.step_pct == '0)
            return 1'b0;
        if (r.screen_on && r.load < gov_cfg.down_thr)
        begin
            if (r.current_freq == r.policy_min)
                return 1'b0;
            if (gov_boost != '0)
                gov_boost = gov_boost - 1'b1;
            lower_freq(pmin, pmax);
            res.relation = REL_DOWN;
        end
        else if (!r.screen_on && r.load <= gov_cfg.down_thr_off)
        begin
            lower_freq(pmin, pmax);
            res.relation = REL_DOWN;
        end
        else if (r.load > gov_cfg.up_thr)
        begin
            if (gov_freq == r.policy_max || !r.screen_on)
                return 1'b0;
            if (gov_cfg.boost_en && gov_boost >= gov_cfg.boost_trig)
            begin
                lvl = longint'(gov_cfg.boost_top) - longint'(gov_boost);
                f = pmax - lvl;
                if (f < 0)
                    f = 0;
                if (f > longint'(FREQ_TOP))
                    f = longint'(FREQ_TOP);
                gov_freq = freq_t'(f);
                if (lvl == 0)
                    gov_boost = '0;
            end
            else
            begin
                f = longint'(gov_freq) + step_of(pmax);
                gov_freq = (f > longint'(FREQ_TOP)) ? FREQ_TOP : freq_t'(f);
                if (gov_boost != COUNTER_MAX)
                    gov_boost = gov_boost + 1'b1;
            end
            res.relation = REL_UP;
        end
        else
            return 1'b0;
        res.target_freq = gov_freq;
        return 1'b1;
    endfunction

    initial
    begin
        gov_res_t want;
        rx_mode_t mode;
        int       phase_left;
        phase_left = 0;
        mode = RX_OPEN;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
            begin
                if (due_targets.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got target_freq %0h relation %0b",
                             $time, res_if.target_freq, res_if.relation);
                end
                else
                begin
                    want = due_targets.pop_front();
                    if (res_if.target_freq !== want.target_freq)
                    begin
                        mismatches++;
                        $display("%0t: target_freq expected %0h got %0h",
                                 $time, want.target_freq, res_if.target_freq);
                    end
                    if (res_if.relation !== want.relation)
                    begin
                        mismatches++;
                        $display("%0t: relation expected %0b got %0b",
                                 $time, want.relation, res_if.relation);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(RX_HEAVY, RX_OPEN));
                    phase_left = $urandom_range(60, 8);
                end
                phase_left--;
                case (mode)
                    RX_OPEN:  res_if.ready <= 1'b1;
                    RX_LIGHT: res_if.ready <= ($urandom_range(3, 0) != 0);
                    default:  res_if.ready <= ($urandom_range(3, 0) == 0);
                endcase
            end
        end
    end

    task automatic pace();
        if (steady)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
            burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(12, 0);
        end
    endtask

    task automatic offer(input gov_req_t r);
        gov_res_t res;
        req_if.valid        <= 1'b1;
        req_if.req_type     <= r.req_type;
        req_if.load         <= r.load;
        req_if.screen_on    <= r.screen_on;
        req_if.current_freq <= r.current_freq;
        req_if.policy_min   <= r.policy_min;
        req_if.policy_max   <= r.policy_max;
        req_if.new_freq     <= r.new_freq;
        do @(posedge clk); while (!req_if.ready);
        if (govern(r, res))
            due_targets.push_back(res);
        pace();
    endtask

    function automatic gov_req_t sample(int load, bit disp, freq_t cur, freq_t pmin,
                                        freq_t pmax);
        gov_req_t r;
        r = '0;
        r.req_type = ~REQ_NOTICE;
        r.load = load[PCT_W-1:0];
        r.screen_on = disp;
        r.current_freq = cur;
        r.policy_min = pmin;
        r.policy_max = pmax;
        r.new_freq = freq_t'($urandom);
        return r;
    endfunction

    function automatic gov_req_t notice(freq_t pmin, freq_t pmax, freq_t nf);
        gov_req_t r;
        r = '0;
        r.req_type = REQ_NOTICE;
        r.load = PCT_W'($urandom_range(127, 0));
        r.screen_on = 1'($urandom_range(1, 0));
        r.current_freq = freq_t'($urandom);
        r.policy_min = pmin;
        r.policy_max = pmax;
        r.new_freq = nf;
        return r;
    endfunction

    function automatic freq_t in_policy();
        return freq_t'($urandom_range(pol_max, pol_min));
    endfunction

    function automatic int rand_load();
        int k;
        k = $urandom_range(19, 0);
        if (k < 9)
            return $urandom_range(100, 75);
        else if (k < 16)
            return $urandom_range(50, 0);
        else if (k < 19)
            return $urandom_range(100, 0);
        return $urandom_range(127, 101);
    endfunction

    function automatic void new_policy();
        case ($urandom_range(9, 0))
            0:
            begin
                pol_max = FREQ_TOP;
                pol_min = $urandom_range(1, 0) ? '0 : freq_t'($urandom_range(1000, 0));
            end
            1:
            begin
                pol_max = freq_t'($urandom_range(19, 0));
                pol_min = freq_t'($urandom_range(pol_max, 0));
            end
            2:
            begin
                pol_max = freq_t'($urandom);
                pol_min = pol_max;
            end
            default:
            begin
                pol_max = freq_t'($urandom_range(FREQ_TOP, 100));
                pol_min = freq_t'($urandom_range(pol_max / 2, 0));
            end
        endcase
    endfunction

    task automatic run_mixed(int n);
        int       pick;
        logic [127:0] bits;
        freq_t    cur;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 4)
            begin
                new_policy();
                offer(notice(pol_min, pol_max, in_policy()));
            end
            else if (pick < 12)
                offer(notice(pol_min, pol_max,
                             $urandom_range(1, 0) ? in_policy() : freq_t'($urandom)));
            else if (pick < 22)
            begin
                bits = {$urandom, $urandom, $urandom, $urandom};
                offer(bits[$bits(gov_req_t)-1:0]);
            end
            else
            begin
                case ($urandom_range(4, 0))
                    0:       cur = pol_min;
                    1:       cur = in_policy();
                    default: cur = gov_freq;
                endcase
                offer(sample(rand_load(), $urandom_range(5, 0) != 0, cur, pol_min, pol_max));
            end
        end
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        while (due_targets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [APB_DATA_W-1:0] reg_value(cfg_t c, reg_idx_t idx);
        case (idx)
            REG_UP_THR:       return APB_DATA_W'(c.up_thr);
            REG_DOWN_THR:     return APB_DATA_W'(c.down_thr);
            REG_DOWN_THR_OFF: return APB_DATA_W'(c.down_thr_off);
            REG_STEP_PCT:     return APB_DATA_W'(c.step_pct);
            REG_BOOST_EN:     return APB_DATA_W'(c.boost_en);
            REG_BOOST_TRIG:   return APB_DATA_W'(c.boost_trig);
            default:          return APB_DATA_W'(c.boost_top);
        endcase
    endfunction

    task automatic apb_access(input reg_idx_t idx, input bit wr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input cfg_t c);
        reg_idx_t              idx;
        logic [APB_DATA_W-1:0] rd;
        settle();
        for (int k = REG_UP_THR; k <= REG_BOOST_TOP; k++)
        begin
            idx = reg_idx_t'(k);
            apb_access(idx, 1'b1, reg_value(c, idx), rd);
        end
        gov_cfg = c;
        for (int k = REG_UP_THR; k <= REG_BOOST_TOP; k++)
        begin
            idx = reg_idx_t'(k);
            apb_access(idx, 1'b0, '0, rd);
            if (rd !== reg_value(c, idx))
            begin
                mismatches++;
                $display("%0t: register %s read expected %0h got %0h",
                         $time, idx.name(), reg_value(c, idx), rd);
            end
        end
    endtask

    function automatic cfg_t reset_cfg();
        return '{up_thr: UP_THR_RST, down_thr: DOWN_THR_RST,
                 down_thr_off: DOWN_THR_OFF_RST, step_pct: STEP_PCT_RST,
                 boost_en: BOOST_EN_RST, boost_trig: BOOST_TRIG_RST,
                 boost_top: BOOST_TOP_RST};
    endfunction

    task automatic test_directed();
        pol_min = 1000;
        pol_max = 100000;
        offer(notice(pol_min, pol_max, 50000));
        repeat (10) offer(sample(100, 1'b1, gov_freq, pol_min, pol_max));
        offer(sample(20, 1'b0, pol_min, pol_min, pol_max));
        offer(sample(45, 1'b0, 60000, pol_min, pol_max));
        offer(sample(34, 1'b1, 60000, pol_min, pol_max));
        offer(sample(35, 1'b1, 60000, pol_min, pol_max));
        offer(sample(100, 1'b0, 60000, pol_min, pol_max));
        offer(sample(0, 1'b1, pol_min, pol_min, pol_max));
        // A step larger than the requested frequency drops straight to the minimum.
        offer(notice(10, 20, 15));
        offer(sample(0, 1'b1, 15, 10, FREQ_TOP));
        // Stepping up past the top of the frequency range saturates.
        offer(notice('0, '0, FREQ_TOP - freq_t'(15)));
        offer(sample(127, 1'b1, gov_freq, '0, FREQ_TOP));
        offer(sample(100, 1'b1, gov_freq, '0, FREQ_TOP));
        // A tiny policy maximum makes the step fall back to its fixed size.
        offer(notice('0, 10, 3));
        offer(sample(100, 1'b1, 3, '0, 10));
        offer(notice('0, FREQ_TOP, 7));
        pol_min = '0;
        pol_max = FREQ_TOP;
    endtask

    task automatic test_backpressure();
        settle();
        steady = 1'b1;
        hold_cycles = 300;
        pol_min = '0;
        pol_max = FREQ_TOP;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 2)
                offer(sample(0, 1'b1, pol_max, pol_min, pol_max));
            else
                offer(sample(100, 1'b1, gov_freq, pol_min, pol_max));
        end
        steady = 1'b0;
    endtask

    task automatic test_counter_saturation();
        cfg_t c;
        c = reset_cfg();
        c.boost_en = 1'b0;
        c.step_pct = 1;
        set_config(c);
        for (int i = 0; i < 280; i++)
        begin
            if (gov_freq == FREQ_TOP)
                offer(notice('0, '0, '0));
            offer(sample(100, 1'b1, gov_freq, '0, FREQ_TOP));
        end
        // Counter far above the ceiling: the boost lands past the top and saturates.
        c.boost_en = 1'b1;
        c.boost_trig = 8'd255;
        c.boost_top = 8'd0;
        set_config(c);
        offer(notice('0, '0, '0));
        repeat (3) offer(sample(100, 1'b1, gov_freq, '0, FREQ_TOP));
        c.boost_top = 8'd255;
        set_config(c);
        offer(notice('0, '0, '0));
        repeat (2) offer(sample(100, 1'b1, gov_freq, '0, FREQ_TOP));
        // A ceiling far above the counter pushes the boost below zero.
        c.boost_trig = 8'd0;
        set_config(c);
        offer(notice('0, 10, 5));
        repeat (3) offer(sample(100, 1'b1, gov_freq, '0, 10));
    endtask

    task automatic test_config_sweep();
        cfg_t c;
        set_config('{up_thr: 7'd0, down_thr: 7'd0, down_thr_off: 7'd0, step_pct: 7'd127,
                     boost_en: 1'b1, boost_trig: 8'd0, boost_top: 8'd255});
        run_mixed(170);
        set_config('{up_thr: 7'd127, down_thr: 7'd127, down_thr_off: 7'd127,
                     step_pct: 7'd1, boost_en: 1'b0, boost_trig: 8'd255, boost_top: 8'd0});
        run_mixed(170);
        set_config('{up_thr: 7'd100, down_thr: 7'd100, down_thr_off: 7'd100,
                     step_pct: 7'd100, boost_en: 1'b1, boost_trig: 8'd1, boost_top: 8'd3});
        run_mixed(170);
        c = reset_cfg();
        c.step_pct = '0;
        set_config(c);
        run_mixed(40);
        repeat (3)
        begin
            c.up_thr = PCT_W'($urandom_range(127, 0));
            c.down_thr = PCT_W'($urandom_range(127, 0));
            c.down_thr_off = PCT_W'($urandom_range(127, 0));
            c.step_pct = PCT_W'($urandom_range(127, 1));
            c.boost_en = 1'($urandom_range(1, 0));
            c.boost_trig = CNT_W'($urandom_range(255, 0));
            c.boost_top = CNT_W'($urandom_range(255, 0));
            set_config(c);
            run_mixed(170);
        end
        set_config(reset_cfg());
        run_mixed(250);
    endtask

    initial
    begin
        mismatches = 0;
        hold_cycles = 0;
        burst_left = 0;
        steady = 1'b0;
        gov_freq = '0;
        gov_boost = '0;
        gov_cfg = reset_cfg();
        rst_n = 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        req_if.valid        <= 1'b0;
        req_if.req_type     <= 1'b0;
        req_if.load         <= '0;
        req_if.screen_on    <= 1'b0;
        req_if.current_freq <= '0;
        req_if.policy_min   <= '0;
        req_if.policy_max   <= '0;
        req_if.new_freq     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_counter_saturation();
        test_config_sweep();

        settle();
        if (mismatches == 0 && due_targets.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
